// ===== hw/rtl/maidr_pkg.sv =====
// maidr_pkg: shared types and constants of the MMIO register block with ALU, IRQ and DMA.
// Used by maidr_alu, maidr_core and mmio_alu_irq_dma_regs_top. No dependencies.
`timescale 1ns / 1ps

package maidr_pkg;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MSI_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOST_MASK  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY      = 2'd2;

   localparam logic [63:0] HOST_MASK_RESET = 64'h0000_0000_0fff_ffff;
   localparam logic [15:0] DELAY_RESET     = 16'd100;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [19:0] ADDR_ID        = 20'h00000;
   localparam logic [19:0] ADDR_OPERAND_A = 20'h00010;
   localparam logic [19:0] ADDR_OPERAND_B = 20'h00014;
   localparam logic [19:0] ADDR_OPCODE    = 20'h00018;
   localparam logic [19:0] ADDR_ALU       = 20'h00030;
   localparam logic [19:0] ADDR_IRQ_STAT  = 20'h00040;
   localparam logic [19:0] ADDR_IRQ_RAISE = 20'h00044;
   localparam logic [19:0] ADDR_IRQ_CLEAR = 20'h00048;
   localparam logic [19:0] ADDR_DMA_SRC   = 20'h00080;
   localparam logic [19:0] ADDR_DMA_DST   = 20'h00088;
   localparam logic [19:0] ADDR_DMA_LEN   = 20'h00090;
   localparam logic [19:0] ADDR_DMA_CMD   = 20'h00098;
   localparam logic [19:0] ADDR_WIDE_BASE = 20'h00080;

   localparam logic [3:0] SIZE_WORD  = 4'd4;
   localparam logic [3:0] SIZE_DWORD = 4'd8;

   localparam logic [31:0] ID_VALUE   = 32'h1234_5678;
   localparam logic [31:0] ALU_ADD    = 32'd1;
   localparam logic [31:0] ALU_MUL    = 32'd2;
   localparam logic [31:0] ALU_NONE   = 32'h0000_00ff;

   localparam int CMD_RUN_BIT  = 0;
   localparam int CMD_HOST_BIT = 1;
   localparam int CMD_IRQ_BIT  = 2;
   localparam logic [31:0] IRQ_DMA_MASK = 32'h0000_0004;

   typedef struct packed {
      logic [1:0]  operation;
      logic [19:0] address;
      logic [3:0]  access_size;
      logic [63:0] write_data;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        irq_line;
      logic        msi_pulse;
      logic        transfer_valid;
      logic        transfer_to_host;
      logic [63:0] transfer_host_address;
      logic [11:0] transfer_buffer_offset;
      logic [12:0] transfer_length;
      logic        range_error;
   } rsp_type;

   typedef struct packed {
      logic        msi_mode;
      logic [63:0] host_address_mask;
      logic [15:0] transfer_delay_ticks;
   } cfg_type;

endpackage

// ===== hw/rtl/mmio_alu_irq_dma_regs_top.sv =====
// Usage:
//   req_*  : input items (bus read, bus write or timer tick), valid/ready.
//   rsp_*  : one result item per input item, in order, valid/ready.
//   csr_*  : configuration writes (msi mode, host address mask, transfer
//            delay); always ready. The user must write them only while the block is idle (not enforced).
// Structure: input register, one pass of decode/ALU/IRQ/DMA logic, result
// register. The state is updated as the item moves into the result register,
// so the next item sees it.
// Throughput: one item per cycle while rsp_ready is high; the 32x32 multiply
// of the ALU read sits between the operand registers and the result register.
// Reset (synchronous): both stages empty, registers to their reset values,
// config to msi off, mask 0x0fffffff, delay 100 ticks.
// Stall: while rsp_ready is low the result holds; one more item is taken
// into the input register, then req_ready drops.
// Depends on maidr_pkg, maidr_core, maidr_alu.
`timescale 1ns / 1ps

module mmio_alu_irq_dma_regs_top #(
   parameter int unsigned BUFFER_BYTES = 4096,
   parameter int unsigned BUFFER_BASE  = 262144
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  maidr_pkg::req_type                   req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output maidr_pkg::rsp_type                   rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [maidr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                          csr_data
);

   maidr_pkg::cfg_type cfg_ff, cfg_in;
   maidr_pkg::req_type in_ff;
   logic               in_valid_ff, in_valid_in;
   maidr_pkg::rsp_type out_ff;
   logic               out_valid_ff, out_valid_in;
   maidr_pkg::rsp_type core_res;
   logic               fire;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            maidr_pkg::CSR_MSI_MODE:  cfg_in.msi_mode             = csr_data[0];
            maidr_pkg::CSR_HOST_MASK: cfg_in.host_address_mask    = csr_data;
            maidr_pkg::CSR_DELAY:     cfg_in.transfer_delay_ticks = csr_data[15:0];
            default: ;
         endcase
      end
   end

   maidr_core #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .BUFFER_BASE  (BUFFER_BASE)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_ff),
      .cfg   (cfg_ff),
      .res   (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.msi_mode             <= 1'b0;
         cfg_ff.host_address_mask    <= maidr_pkg::HOST_MASK_RESET;
         cfg_ff.transfer_delay_ticks <= maidr_pkg::DELAY_RESET;
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_item;
      end
      if (fire) begin
         out_ff <= core_res;
      end
   end

endmodule

// ===== hw/rtl/maidr_alu.sv =====
// maidr_alu: sum or product of the two operand registers, selected by the opcode; 0xff for any other opcode.
// Depends on maidr_pkg.
`timescale 1ns / 1ps

module maidr_alu (
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   input  logic [31:0] opcode,
   output logic [31:0] result
);

   logic [31:0] sum;
   logic [31:0] prod;

   assign sum  = operand_a + operand_b;
   assign prod = operand_a * operand_b;

   always_comb begin
      priority if (opcode == maidr_pkg::ALU_ADD) begin
         result = sum;
      end else if (opcode == maidr_pkg::ALU_MUL) begin
         result = prod;
      end else begin
         result = maidr_pkg::ALU_NONE;
      end
   end

endmodule

// ===== hw/rtl/maidr_core.sv =====
// maidr_core: register state, bus decode, interrupt logic and DMA delay/request logic.
// Computes one result per item from the staged item; depends on maidr_pkg, maidr_alu.
`timescale 1ns / 1ps

module maidr_core #(
   parameter int unsigned BUFFER_BYTES = 4096,
   parameter int unsigned BUFFER_BASE  = 262144
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  maidr_pkg::req_type  item,
   input  maidr_pkg::cfg_type  cfg,
   output maidr_pkg::rsp_type  res
);

   localparam logic [63:0] BufBase  = 64'(BUFFER_BASE);
   localparam logic [63:0] BufBytes = 64'(BUFFER_BYTES);

   logic [31:0] opa_ff, opa_in;
   logic [31:0] opb_ff, opb_in;
   logic [31:0] opcode_ff, opcode_in;
   logic [31:0] status_ff, status_in;
   logic        level_ff, level_in;
   logic [63:0] src_ff, src_in;
   logic [63:0] dst_ff, dst_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] cmd_ff, cmd_in;
   logic [15:0] delay_ff, delay_in;

   logic [31:0] alu_result;

   maidr_alu u_alu (
      .operand_a (opa_ff),
      .operand_b (opb_ff),
      .opcode    (opcode_ff),
      .result    (alu_result)
   );

   always_comb begin
      logic        size_ok;
      logic        running;
      logic [63:0] wide;
      logic [31:0] stat_n;
      logic        to_host;
      logic [63:0] buf_addr;
      logic [63:0] host_addr;
      logic [63:0] rel;
      logic        in_range;

      opa_in    = opa_ff;
      opb_in    = opb_ff;
      opcode_in = opcode_ff;
      status_in = status_ff;
      level_in  = level_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      delay_in  = delay_ff;
      res       = '0;

      if (item.address < maidr_pkg::ADDR_WIDE_BASE) begin
         size_ok = item.access_size == maidr_pkg::SIZE_WORD;
      end else begin
         size_ok = item.access_size == maidr_pkg::SIZE_WORD ||
                   item.access_size == maidr_pkg::SIZE_DWORD;
      end
      running  = cmd_ff[maidr_pkg::CMD_RUN_BIT];
      wide     = (item.access_size == maidr_pkg::SIZE_WORD) ?
                 {32'd0, item.write_data[31:0]} : item.write_data;
      stat_n   = status_ff;
      to_host  = cmd_ff[maidr_pkg::CMD_HOST_BIT];
      buf_addr = to_host ? src_ff : dst_ff;
      host_addr = to_host ? dst_ff : src_ff;
      rel      = buf_addr - BufBase;
      in_range = (buf_addr >= BufBase) && (rel <= BufBytes) && (len_ff <= BufBytes - rel);

      unique case (item.operation)
         maidr_pkg::OP_READ: begin
            if (!size_ok) begin
               res.read_data = '1;
            end else begin
               unique case (item.address)
                  maidr_pkg::ADDR_ID:        res.read_data = {32'd0, maidr_pkg::ID_VALUE};
                  maidr_pkg::ADDR_OPERAND_A: res.read_data = {32'd0, opa_ff};
                  maidr_pkg::ADDR_OPERAND_B: res.read_data = {32'd0, opb_ff};
                  maidr_pkg::ADDR_OPCODE:    res.read_data = {32'd0, opcode_ff};
                  maidr_pkg::ADDR_ALU:       res.read_data = {32'd0, alu_result};
                  maidr_pkg::ADDR_IRQ_STAT:  res.read_data = {32'd0, status_ff};
                  maidr_pkg::ADDR_DMA_SRC:   res.read_data = src_ff;
                  maidr_pkg::ADDR_DMA_DST:   res.read_data = dst_ff;
                  maidr_pkg::ADDR_DMA_LEN:   res.read_data = len_ff;
                  maidr_pkg::ADDR_DMA_CMD:   res.read_data = cmd_ff;
                  default:                   res.read_data = '1;
               endcase
            end
         end
         maidr_pkg::OP_WRITE: begin
            if (size_ok) begin
               unique case (item.address)
                  maidr_pkg::ADDR_OPERAND_A: opa_in    = item.write_data[31:0];
                  maidr_pkg::ADDR_OPERAND_B: opb_in    = item.write_data[31:0];
                  maidr_pkg::ADDR_OPCODE:    opcode_in = item.write_data[31:0];
                  maidr_pkg::ADDR_IRQ_RAISE: begin
                     stat_n    = status_ff | item.write_data[31:0];
                     status_in = stat_n;
                     if (stat_n != '0) begin
                        if (cfg.msi_mode) begin
                           res.msi_pulse = 1'b1;
                        end else begin
                           level_in = 1'b1;
                        end
                     end
                  end
                  maidr_pkg::ADDR_IRQ_CLEAR: begin
                     stat_n    = status_ff & ~item.write_data[31:0];
                     status_in = stat_n;
                     if (stat_n == '0 && !cfg.msi_mode) begin
                        level_in = 1'b0;
                     end
                  end
                  maidr_pkg::ADDR_DMA_SRC: if (!running) src_in = wide;
                  maidr_pkg::ADDR_DMA_DST: if (!running) dst_in = wide;
                  maidr_pkg::ADDR_DMA_LEN: if (!running) len_in = wide;
                  maidr_pkg::ADDR_DMA_CMD: begin
                     if (wide[maidr_pkg::CMD_RUN_BIT] && !running) begin
                        cmd_in   = wide;
                        delay_in = cfg.transfer_delay_ticks;
                     end
                  end
                  default: ;
               endcase
            end
         end
         maidr_pkg::OP_TICK: begin
            if (running) begin
               if (delay_ff > 16'd1) begin
                  delay_in = delay_ff - 16'd1;
               end else begin
                  delay_in = '0;
                  if (in_range) begin
                     res.transfer_valid         = 1'b1;
                     res.transfer_to_host       = to_host;
                     res.transfer_host_address  = host_addr & cfg.host_address_mask;
                     res.transfer_buffer_offset = rel[11:0];
                     res.transfer_length        = len_ff[12:0];
                  end else begin
                     res.range_error = 1'b1;
                  end
                  cmd_in[maidr_pkg::CMD_RUN_BIT] = 1'b0;
                  if (cmd_ff[maidr_pkg::CMD_IRQ_BIT]) begin
                     status_in = status_ff | maidr_pkg::IRQ_DMA_MASK;
                     if (cfg.msi_mode) begin
                        res.msi_pulse = 1'b1;
                     end else begin
                        level_in = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase

      res.irq_line = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opa_ff    <= 32'd1;
         opb_ff    <= 32'd2;
         opcode_ff <= maidr_pkg::ALU_ADD;
         status_ff <= '0;
         level_ff  <= 1'b0;
         src_ff    <= '0;
         dst_ff    <= '0;
         len_ff    <= '0;
         cmd_ff    <= '0;
         delay_ff  <= '0;
      end else if (fire) begin
         opa_ff    <= opa_in;
         opb_ff    <= opb_in;
         opcode_ff <= opcode_in;
         status_ff <= status_in;
         level_ff  <= level_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         len_ff    <= len_in;
         cmd_ff    <= cmd_in;
         delay_ff  <= delay_in;
      end
   end

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.operation == maidr_pkg::OP_TICK && cmd_ff[maidr_pkg::CMD_RUN_BIT] &&
      delay_ff <= 16'd1 |=> !cmd_ff[maidr_pkg::CMD_RUN_BIT])
      else $error("run bit not cleared on completion");

   a_dma_locked: assert property (@(posedge clock) disable iff (reset)
      cmd_ff[maidr_pkg::CMD_RUN_BIT] |=> $stable(src_ff) && $stable(dst_ff) && $stable(len_ff))
      else $error("DMA descriptor changed while running");

   a_req_xor_err: assert property (@(posedge clock) disable iff (reset)
      res.transfer_valid |-> !res.range_error)
      else $error("request issued with range error");

   a_pulse_mode: assert property (@(posedge clock) disable iff (reset)
      res.msi_pulse |-> cfg.msi_mode && !level_in == !level_ff)
      else $error("message pulse outside message mode");

endmodule
